### src/mcal_pkg.sv
// ----------------------------------------------------------------------------
// mcal_pkg: shared types and constants for the masked cosine angle loss block
// Payload structs, fixed-point constants and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package mcal_pkg;

	localparam int CordicSteps = 16;
	localparam int MaxPixels   = 1048576;
	localparam int CntW        = 21;
	localparam int SumW        = 36;
	localparam logic [CntW-1:0] CntCap = (MaxPixels < 2097151) ?
		CntW'(MaxPixels) : {CntW{1'b1}};
	localparam logic signed [17:0] PiQ12     = 18'sd12868;
	localparam logic signed [17:0] TwoPiQ12  = 18'sd25736;
	localparam logic signed [17:0] HalfPiQ12 = 18'sd6434;
	localparam logic signed [33:0] GainQ30   = 34'sd652032874;
	localparam logic signed [33:0] OneQ30    = 34'sd1073741824;

	localparam logic [15:0] RstWeight    = 16'd4096;
	localparam logic [15:0] RstThreshold = 16'hB000;

	typedef enum logic {
		REG_WEIGHT    = 1'b0,
		REG_THRESHOLD = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic signed [15:0] pred_angle;
		logic signed [15:0] true_angle;
		logic               last_pixel;
	} in_req_t;

	typedef struct packed {
		logic signed [15:0] grad_raw;
		logic               counted;
		logic               batch_done;
		logic [23:0]        loss_value;
		logic [20:0]        valid_count;
		logic [20:0]        grad_scale;
	} out_req_t;

	// classified item passed from front to back
	typedef struct packed {
		logic signed [15:0] angle;
		logic               flip;
		logic               valid;
		logic               last;
	} cls_t;

	function automatic logic signed [33:0] atan_q30(input logic [4:0] i);
		case (i)
			5'd0:  atan_q30 = 34'sd843314856;
			5'd1:  atan_q30 = 34'sd497837829;
			5'd2:  atan_q30 = 34'sd263043836;
			5'd3:  atan_q30 = 34'sd133525158;
			5'd4:  atan_q30 = 34'sd67021686;
			5'd5:  atan_q30 = 34'sd33543515;
			5'd6:  atan_q30 = 34'sd16775850;
			5'd7:  atan_q30 = 34'sd8388437;
			5'd8:  atan_q30 = 34'sd4194282;
			5'd9:  atan_q30 = 34'sd2097149;
			5'd10: atan_q30 = 34'sd1048575;
			5'd11: atan_q30 = 34'sd524287;
			5'd12: atan_q30 = 34'sd262143;
			5'd13: atan_q30 = 34'sd131071;
			5'd14: atan_q30 = 34'sd65535;
			5'd15: atan_q30 = 34'sd32767;
			5'd16: atan_q30 = 34'sd16383;
			5'd17: atan_q30 = 34'sd8191;
			5'd18: atan_q30 = 34'sd4095;
			5'd19: atan_q30 = 34'sd2047;
			5'd20: atan_q30 = 34'sd1023;
			5'd21: atan_q30 = 34'sd511;
			5'd22: atan_q30 = 34'sd255;
			5'd23: atan_q30 = 34'sd127;
			default: atan_q30 = '0;
		endcase
	endfunction

endpackage

### src/mcal_front.sv
// ----------------------------------------------------------------------------
// mcal_front: input classification
// Masks by threshold, wraps the angle difference and folds it to +-pi/2.
// ----------------------------------------------------------------------------
module mcal_front import mcal_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  in_req_t            in_data,
	input  logic signed [15:0] threshold,
	output logic               q_valid,
	input  logic               q_stall,
	output cls_t               q_data
);
	logic signed [17:0] d0, d1, d2;
	cls_t c;
	logic full_q;

	always_comb begin
		d0 = 18'(in_data.pred_angle) - 18'(in_data.true_angle);
		d1 = d0;
		for (int k = 0; k < 4; k++) begin
			if (d1 >= PiQ12) begin
				d1 = d1 - TwoPiQ12;
			end else if (d1 < -PiQ12) begin
				d1 = d1 + TwoPiQ12;
			end
		end
		d2 = d1;
		c.flip = 1'b0;
		if (d1 > HalfPiQ12) begin
			d2 = d1 - PiQ12;
			c.flip = 1'b1;
		end else if (d1 < -HalfPiQ12) begin
			d2 = d1 + PiQ12;
			c.flip = 1'b1;
		end
		c.angle = d2[15:0];
		c.valid = in_data.true_angle > threshold;
		c.last  = in_data.last_pixel;
	end

	// two-entry queue
	cls_t buf_q [2];
	logic [1:0] cnt_q;
	logic rd_ptr_q, wr_ptr_q;
	logic push, pop;

	assign full_q   = (cnt_q == 2'd2);
	assign in_stall = full_q;
	assign push     = in_valid && !full_q;
	assign q_valid  = (cnt_q != 2'd0);
	assign pop      = q_valid && !q_stall;
	assign q_data   = buf_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_ptr_q] <= c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			rd_ptr_q <= 1'b0;
			wr_ptr_q <= 1'b0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end
endmodule

### src/mcal_back.sv
// ----------------------------------------------------------------------------
// mcal_back: CORDIC, accumulation and batch division
// Iterative CORDIC one rotation a cycle, then restoring dividers for the
// batch loss and gradient scale.
// ----------------------------------------------------------------------------
module mcal_back import mcal_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_valid,
	output logic        q_stall,
	input  cls_t        q_data,
	input  logic [15:0] weight,
	output logic        out_valid,
	input  logic        out_stall,
	output out_req_t    out_data
);
	typedef enum logic [2:0] {ST_IDLE, ST_ROT, ST_POST, ST_MUL, ST_DIV, ST_OUT} st_t;

	st_t st_q, st_d;
	cls_t item_q;
	logic signed [33:0] x_q, y_q, z_q;
	logic [4:0] it_q;
	logic [SumW-1:0] sum_q;
	logic [CntW-1:0] cnt_q;
	logic [51:0] num_q;     // loss dividend, becomes quotient
	logic [41:0] den_q;     // divisor * 1024 (fits 31 bits)
	logic [51:0] rem_q;
	logic [20:0] snum_q, srem_q;
	logic [5:0] dcnt_q;
	logic signed [49:0] prod_q;
	out_req_t res_q;
	logic res_v_q;

	logic signed [33:0] xs, ys, s, cc, v;
	logic [52:0] rtry;
	logic [21:0] strry;
	logic [CntW-1:0] div_cnt;
	logic signed [49:0] gr;
	logic [SumW:0] sum_n;
	logic out_free;

	assign q_stall   = (st_q != ST_IDLE);
	assign out_valid = res_v_q;
	assign out_data  = res_q;
	assign out_free  = !res_v_q || !out_stall;

	always_comb begin
		xs = x_q >>> it_q;
		ys = y_q >>> it_q;
		s  = item_q.flip ? -y_q : y_q;
		cc = item_q.flip ? -x_q : x_q;
		v  = OneQ30 - cc;
		if (v < 0) begin
			v = '0;
		end
		sum_n = {1'b0, sum_q} + (SumW+1)'((v + 34'sd32768) >>> 16);
		gr = (prod_q + 50'sd536870912) >>> 30;
		div_cnt = (cnt_q == '0) ? CntW'(1) : cnt_q;
		rtry  = {rem_q, num_q[51]} - {11'd0, den_q};
		strry = {srem_q, snum_q[20]} - {1'b0, div_cnt};
	end

	always_comb begin
		st_d = st_q;
		case (st_q)
			ST_IDLE: if (q_valid) st_d = q_data.valid ? ST_ROT :
				(q_data.last ? ST_MUL : ST_OUT);
			ST_ROT:  if (it_q == 5'(CordicSteps - 1)) st_d = ST_POST;
			ST_POST: st_d = item_q.last ? ST_MUL : ST_OUT;
			ST_MUL:  st_d = ST_DIV;
			ST_DIV:  if (dcnt_q == 6'd51) st_d = ST_OUT;
			ST_OUT:  if (out_free) st_d = ST_IDLE;
			default: st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= ST_IDLE;
			sum_q   <= '0;
			cnt_q   <= '0;
			res_v_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (res_v_q && !out_stall) begin
				res_v_q <= 1'b0;
			end
			if (st_q == ST_POST) begin
				sum_q <= sum_n[SumW] ? {SumW{1'b1}} : sum_n[SumW-1:0];
				if (cnt_q < CntCap) begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
			if (st_q == ST_OUT && out_free) begin
				res_v_q <= 1'b1;
				if (item_q.last) begin
					sum_q <= '0;
					cnt_q <= '0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			ST_IDLE: begin
				item_q <= q_data;
				x_q    <= GainQ30;
				y_q    <= '0;
				z_q    <= 34'(q_data.angle) <<< 18;
				it_q   <= '0;
				prod_q <= '0;
			end
			ST_ROT: begin
				if (!z_q[33]) begin
					x_q <= x_q - ys;
					y_q <= y_q + xs;
					z_q <= z_q - atan_q30(it_q);
				end else begin
					x_q <= x_q + ys;
					y_q <= y_q - xs;
					z_q <= z_q + atan_q30(it_q);
				end
				it_q <= it_q + 1'b1;
			end
			ST_POST: prod_q <= $signed({1'b0, weight}) * s;
			ST_MUL: begin
				num_q  <= weight * sum_q;
				den_q  <= {11'd0, div_cnt, 10'd0};
				rem_q  <= '0;
				snum_q <= 21'h100000;
				srem_q <= '0;
				dcnt_q <= '0;
			end
			ST_DIV: begin
				if (!rtry[52]) begin
					rem_q <= rtry[51:0];
					num_q <= {num_q[50:0], 1'b1};
				end else begin
					rem_q <= {rem_q[50:0], num_q[51]};
					num_q <= {num_q[50:0], 1'b0};
				end
				if (dcnt_q < 6'd21) begin
					if (!strry[21]) begin
						srem_q <= strry[20:0];
						snum_q <= {snum_q[19:0], 1'b1};
					end else begin
						srem_q <= {srem_q[19:0], snum_q[20]};
						snum_q <= {snum_q[19:0], 1'b0};
					end
				end
				dcnt_q <= dcnt_q + 1'b1;
			end
			ST_OUT: begin
				if (out_free) begin
					res_q.counted    <= item_q.valid;
					res_q.batch_done <= item_q.last;
					if (!item_q.valid) begin
						res_q.grad_raw <= '0;
					end else if (gr > 50'sd32767) begin
						res_q.grad_raw <= 16'sh7FFF;
					end else if (gr < -50'sd32768) begin
						res_q.grad_raw <= 16'sh8000;
					end else begin
						res_q.grad_raw <= gr[15:0];
					end
					if (item_q.last) begin
						res_q.loss_value  <= (num_q[51:24] != '0) ? 24'hFFFFFF : num_q[23:0];
						res_q.valid_count <= cnt_q;
						res_q.grad_scale  <= snum_q;
					end else begin
						res_q.loss_value  <= '0;
						res_q.valid_count <= '0;
						res_q.grad_scale  <= '0;
					end
				end
			end
			default: ;
		endcase
	end
endmodule

### src/masked_cosine_angle_loss.sv
// ----------------------------------------------------------------------------
// masked_cosine_angle_loss: masked 1-cos angle loss with CORDIC gradients
// The back end handles one pixel at a time: a counted pixel is accepted, takes
// 16 CORDIC rotations, is accumulated and gives a result; an ignored one is
// accepted and gives a result. The final pixel of a batch adds the bit-serial
// loss and scale division. Results leave through one output register, so the
// back end only waits when a finished result finds the previous one still
// held. The front end classifies and queues two pixels in registers.
// ----------------------------------------------------------------------------
module masked_cosine_angle_loss import mcal_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_req_t     in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output out_req_t    out_data,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	logic [15:0] weight_q;
	logic [15:0] thr_q;
	logic q_valid, q_stall;
	cls_t q_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weight_q <= RstWeight;
			thr_q    <= RstThreshold;
		end else if (cfg_we && !cfg_index[1]) begin
			case (reg_idx_t'(cfg_index[0]))
				REG_WEIGHT:    weight_q <= cfg_data;
				REG_THRESHOLD: thr_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	mcal_front u_front (
		.clk, .arst_n, .in_valid, .in_stall, .in_data,
		.threshold(signed'(thr_q)),
		.q_valid, .q_stall, .q_data
	);

	mcal_back u_back (
		.clk, .arst_n, .q_valid, .q_stall, .q_data,
		.weight(weight_q),
		.out_valid, .out_stall, .out_data
	);
endmodule
